// ===== design/fdl_pkg.sv =====
`timescale 1ns / 1ps

package fdl_pkg;

  // buffer depth default
  localparam int unsigned DEPTH_DEF = 4096;

  // fixed field widths
  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned DELAY_W   = 21;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 21;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 1'd1;

  // register reset values
  localparam logic [DELAY_W-1:0] DELAY_RST = 21'd256;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd0;

  // saturation bounds of a stored sample
  localparam logic signed [25:0] SAT_MAX = 26'sd8388607;
  localparam logic signed [25:0] SAT_MIN = -26'sd8388608;

endpackage

// ===== design/fractional_feedback_delay_line.sv =====
`timescale 1ns / 1ps

// Fractional feedback delay line. Each transfer on the input stream is one
// signed Q1.23 sample; each output transfer is the sample read delay_samples/256
// items back from the write pointer, linearly interpolated between two neighboring
// buffer entries. The input plus feedback_gain (Q1.15) times that output is
// saturated to 24 bits and written at the write pointer. For each sample the first
// buffer read is issued with the input transfer, the second read follows, then
// interpolation and then the feedback product with the write back; the single
// port of the sample memory and the one multiplier shared by the interpolation
// and the feedback make these separate steps. The last step waits while a
// previous result is still held in the output register. After reset the buffer
// reads as zero: entries not yet written since reset are tracked by the write
// pointer and a wrap flag, so no clearing pass is needed and items are taken at
// once. Delays above DEPTH samples are clamped to DEPTH.
module fractional_feedback_delay_line #(
  parameter int unsigned DEPTH = fdl_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] sample_in
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [23:0] delayed_out
  // configuration writes
  input  logic                           cfg_we,
  input  logic [fdl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fdl_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IW    = AW + 1;
  localparam int unsigned LIM_W = AW + 9;
  localparam int unsigned CW    = (LIM_W > fdl_pkg::DELAY_W) ? LIM_W : fdl_pkg::DELAY_W;
  localparam logic [CW-1:0] LIM = CW'(DEPTH * 256);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RDB,
    S_INT,
    S_FB
  } state_t;

  state_t state_r;

  // configuration
  logic [fdl_pkg::DELAY_W-1:0]       delay_r;
  logic signed [fdl_pkg::GAIN_W-1:0] gain_r;

  // ring state
  logic [AW-1:0] wp_r;
  logic [AW-1:0] wp_nxt;
  logic          wrapped_r;

  // per item working registers
  logic signed [23:0] x_r;
  logic signed [23:0] a_r;
  logic signed [23:0] y_r;
  logic [7:0]         g_r;
  logic [AW-1:0]      ib_r;
  logic               va_r;
  logic               vb_r;

  logic               out_valid_r;
  logic [23:0]        out_data_r;

  // sample memory
  logic signed [23:0] mem [DEPTH];
  logic signed [23:0] rd_data_r;
  logic               rd_en;
  logic               wr_en;
  logic [AW-1:0]      rd_addr;

  // address generation
  logic [CW-1:0] d_ext;
  logic [CW-1:0] d_cl;
  logic [IW-1:0] dint;
  logic [IW-1:0] wp_ext;
  logic [AW-1:0] ia_w;
  logic [AW-1:0] ib_w;

  // shared multiplier and datapath
  logic signed [16:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [41:0] prod;
  logic signed [24:0] diff;
  logic signed [41:0] rnd_int;
  logic signed [41:0] rnd_fb;
  logic signed [25:0] y_sum;
  logic signed [25:0] s_sum;
  logic signed [23:0] s_sat;
  logic signed [23:0] b_val;

  logic accept;
  logic out_free;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    d_ext  = CW'(delay_r);
    d_cl   = (d_ext > LIM) ? LIM : d_ext;
    dint   = IW'(d_cl >> 8);
    wp_ext = IW'(wp_r);
    if (dint > wp_ext) begin
      ia_w = AW'(wp_ext + IW'(DEPTH) - dint);
    end else begin
      ia_w = AW'(wp_ext - dint);
    end
    ib_w   = (ia_w == '0) ? LAST_IDX : (ia_w - AW'(1));
    wp_nxt = (wp_r == LAST_IDX) ? '0 : (wp_r + AW'(1));
  end

  assign rd_en   = accept || (state_r == S_RDB);
  assign wr_en   = (state_r == S_FB) && out_free;
  assign rd_addr = (state_r == S_IDLE) ? ia_w : ib_r;

  // entries never written since reset read as zero
  assign b_val = vb_r ? rd_data_r : '0;

  always_comb begin
    diff = 25'(b_val) - 25'(a_r);
    if (state_r == S_FB) begin
      mul_a = 17'(gain_r);
      mul_b = 25'(y_r);
    end else begin
      mul_a = $signed({9'd0, g_r});
      mul_b = diff;
    end
    prod    = 42'(mul_a) * 42'(mul_b);
    rnd_int = prod + 42'sd128;
    rnd_fb  = prod + 42'sd16384;
    y_sum   = 26'(a_r) + rnd_int[33:8];
    s_sum   = 26'(x_r) + rnd_fb[40:15];
    if (s_sum > fdl_pkg::SAT_MAX) begin
      s_sat = fdl_pkg::SAT_MAX[23:0];
    end else if (s_sum < fdl_pkg::SAT_MIN) begin
      s_sat = fdl_pkg::SAT_MIN[23:0];
    end else begin
      s_sat = s_sum[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= s_sat;
    end else if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= fdl_pkg::DELAY_RST;
      gain_r  <= fdl_pkg::GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fdl_pkg::CFG_DELAY: delay_r <= cfg_wdata[fdl_pkg::DELAY_W-1:0];
        fdl_pkg::CFG_GAIN:  gain_r  <= cfg_wdata[fdl_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer with its registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready && !wr_en) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            x_r     <= in_tdata;
            g_r     <= delay_r[7:0] & {8{d_ext <= LIM}};
            ib_r    <= ib_w;
            va_r    <= wrapped_r || (ia_w < wp_r);
            vb_r    <= wrapped_r || (ib_w < wp_r);
            state_r <= S_RDB;
          end
        end
        S_RDB: begin
          a_r     <= va_r ? rd_data_r : '0;
          state_r <= S_INT;
        end
        S_INT: begin
          y_r     <= y_sum[23:0];
          state_r <= S_FB;
        end
        S_FB: begin
          if (out_free) begin
            out_data_r  <= y_r;
            out_valid_r <= 1'b1;
            wp_r        <= wp_nxt;
            if (wp_r == LAST_IDX) begin
              wrapped_r <= 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_RDB))
    else $error("accepted item did not move to second read");

  a_wp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= LAST_IDX)
    else $error("write pointer beyond buffer depth");

  a_wp_moves_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (wp_r != $past(wp_r))) |-> $past(wr_en))
    else $error("write pointer moved without a buffer write");

  a_result_from_fb: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> $past(state_r == S_FB))
    else $error("result shown outside the feedback step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (!out_valid_r || out_tready))
    else $error("pending result would be overwritten");
`endif

endmodule

// ===== tb/sv/fractional_feedback_delay_line_tb.sv =====
`timescale 1ns / 1ps

module fractional_feedback_delay_line_tb;

  localparam int unsigned DEPTH = fdl_pkg::DEPTH_DEF;
  localparam longint DELAY_CAP = longint'(DEPTH) * 256;
  localparam logic [23:0] S_MAX = 24'h7FFFFF;
  localparam logic [23:0] S_MIN = 24'h800000;
  localparam logic [15:0] G_MAX = 16'h7FFF;
  localparam logic [15:0] G_MIN = 16'h8000;

  // tracks the ring buffer and the registers, queues the expected delayed samples
  class echo_tracker;
    logic [23:0] ring[DEPTH];
    longint wp;
    longint delay;
    longint gain;
    logic [23:0] pending[$];
    int errors;
    int seen;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wp = 0;
      delay = longint'(fdl_pkg::DELAY_RST);
      gain = longint'($signed(fdl_pkg::GAIN_RST));
      errors = 0;
      seen = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_reg(logic [fdl_pkg::CFG_IDX_W-1:0] idx,
                          logic [fdl_pkg::CFG_DAT_W-1:0] value);
      if (idx == fdl_pkg::CFG_DELAY) begin
        delay = longint'(value);
      end else if (idx == fdl_pkg::CFG_GAIN) begin
        gain = longint'($signed(value[fdl_pkg::GAIN_W-1:0]));
      end
    endfunction

    // read-interpolate, then write input plus feedback back at the write pointer
    function void take_sample(logic [23:0] raw);
      longint x, d, dint, frac, ia, ib, a, b, y, fb, s;
      x = longint'($signed(raw));
      d = (delay > DELAY_CAP) ? DELAY_CAP : delay;
      dint = d >>> 8;
      frac = d & 255;
      ia = (wp + DEPTH - dint) % DEPTH;
      ib = (wp + 2 * DEPTH - dint - 1) % DEPTH;
      a = longint'($signed(ring[ia]));
      b = longint'($signed(ring[ib]));
      y = ((256 - frac) * a + frac * b + 128) >>> 8;
      fb = (gain * y + 16384) >>> 15;
      s = x + fb;
      if (s > 8388607) s = 8388607;
      if (s < -8388608) s = -8388608;
      ring[wp] = s[23:0];
      wp = (wp + 1) % DEPTH;
      pending.push_back(y[23:0]);
    endfunction

    task check_echo(logic [23:0] got);
      logic [23:0] want;
      seen++;
      if (pending.size() == 0) begin
        report($sformatf("output transfer %0d with nothing pending: %h", seen, got));
      end else begin
        want = pending.pop_front();
        if (got !== want)
          report($sformatf("delayed_out of transfer %0d: got %h, want %h", seen, got, want));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [fdl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fdl_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;
  logic calm = 1'b0;

  echo_tracker echoes;

  fractional_feedback_delay_line uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // result side: check each transfer, stall at random unless calm
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) echoes.check_echo(out_tdata);
    out_tready <= calm || ($urandom_range(99) >= 27);
  end

  // valid stays high between back-to-back samples, it only drops for a gap
  task automatic send_sample(logic [23:0] x);
    if (!calm && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 27);
    end
    in_tvalid <= 1'b1;
    in_tdata <= x;
    do @(posedge clk); while (!in_tready);
    echoes.take_sample(x);
  endtask

  // stop the input and let the pipe empty before touching registers
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (echoes.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [fdl_pkg::CFG_IDX_W-1:0] idx,
                           logic [fdl_pkg::CFG_DAT_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    echoes.set_reg(idx, value);
  endtask

  task automatic reconfigure(logic [fdl_pkg::DELAY_W-1:0] dly,
                             logic [fdl_pkg::GAIN_W-1:0] g);
    settle();
    write_reg(fdl_pkg::CFG_DELAY, dly);
    write_reg(fdl_pkg::CFG_GAIN,
              {{(fdl_pkg::CFG_DAT_W - fdl_pkg::GAIN_W){1'b0}}, g});
  endtask

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(9))
      0: return S_MAX;
      1: return S_MIN;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [fdl_pkg::DELAY_W-1:0] pick_delay();
    case ($urandom_range(5))
      0: return 21'($urandom);
      1: return 21'($urandom_range(8 * 256));
      2: return 21'($urandom_range(32'(DELAY_CAP), (DEPTH - 6) * 256));
      3: return 21'($urandom_range(21'h1FFFFF, 32'(DELAY_CAP)));
      4: return 21'd0;
      default: return 21'($urandom_range(32'(DELAY_CAP)));
    endcase
  endfunction

  function automatic logic [fdl_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(5))
      0: return G_MAX;
      1: return G_MIN;
      2: return 16'd0;
      3: return 16'($urandom_range(16'h3FFF)) ^ {16{$urandom_range(1) == 1}};
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int phases;
    int count;
    echoes = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one sample delay, no feedback
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(24'd0);
    send_sample(24'hFFFFFF);
    send_sample(24'd1);
    send_sample(S_MAX);

    // full positive feedback drives the write into both saturation rails
    reconfigure(21'd256, G_MAX);
    repeat (3) send_sample(S_MAX);
    repeat (3) send_sample(S_MIN);

    // -1.0 feedback with a one-and-a-half-sample delay
    reconfigure(21'd384, G_MIN);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample(24'd100);

    // oversized delay clamps to the full buffer
    reconfigure(21'h1FFFFF, 16'h4000);
    repeat (2) send_sample(pick_sample());
    reconfigure(21'd0, 16'h4000);
    repeat (2) send_sample(pick_sample());
    reconfigure(21'(DELAY_CAP), G_MAX);
    send_sample(S_MIN);
    // fraction only: blends the entry at the pointer with the one just behind
    reconfigure(21'd255, 16'hC000);
    repeat (2) send_sample(pick_sample());

    // varied data through short and medium delays; one calm stretch
    reconfigure(21'($urandom_range(64 * 256)), 16'($urandom_range(16'h5FFF)));
    for (int i = 0; i < 200; i++) begin
      calm <= (i >= 50 && i < 150);
      send_sample(pick_sample());
    end
    calm <= 1'b0;

    phases = 5;
    for (int p = 0; p < phases; p++) begin
      reconfigure(pick_delay(), pick_gain());
      count = $urandom_range(110, 40);
      repeat (count) send_sample(pick_sample());
    end

    in_tvalid <= 1'b0;
    for (int w = 0; w < 200000 && echoes.pending.size() != 0; w++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (echoes.pending.size() != 0)
      echoes.report($sformatf("%0d delayed samples never came out", echoes.pending.size()));
    if (echoes.errors == 0) begin
      $display("fractional_feedback_delay_line_tb: clean");
    end else begin
      $display("fractional_feedback_delay_line_tb: errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("fractional_feedback_delay_line_tb: errors");
    $finish;
  end

endmodule
